@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the waveform column peak span RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is low.
`define WCPS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wcps assertion failed");

// Same check with a message supplied by the caller.
`define WCPS_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

@@ rtl/core/wcps_pkg.sv @@
// Package for the waveform column peak span block: field widths,
// register indexes, reset values and parameter defaults. No dependencies.
package wcps_pkg;

  // Parameter defaults
  localparam int MaxColumnsDef = 4096;
  localparam int MaxRowsDef    = 2048;
  localparam int SampleBitsDef = 16;

  // Result field widths
  localparam int ColumnW = 12;
  localparam int RowW    = 11;
  localparam int OutTdataW = ((ColumnW + 2 * RowW + 7) / 8) * 8;

  // Configuration port
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 32;
  localparam int CfgColumnsW = 13;
  localparam int CfgFramesW  = 25;
  localparam int CfgRowsW    = 12;

  localparam logic [CfgColumnsW-1:0] ColumnsRst = CfgColumnsW'(1024);
  localparam logic [CfgFramesW-1:0]  FramesRst  = CfgFramesW'(1048576);
  localparam logic [CfgRowsW-1:0]    RowsRst    = CfgRowsW'(512);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_COLUMNS     = 2'd0,
    CFG_FRAME_COUNT = 2'd1,
    CFG_ROWS        = 2'd2
  } cfg_reg_e;

endpackage

@@ rtl/core/wcps_cfg.sv @@
// Configuration registers, effective-value clamping and re-arm sequencing.
// Depends on wcps_pkg.
module wcps_cfg #(
  parameter int MAX_COLUMNS = wcps_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = wcps_pkg::MaxRowsDef,
  localparam int CW = $clog2(MAX_COLUMNS + 1),
  localparam int RW = $clog2(MAX_ROWS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wcps_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [wcps_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic [CW-1:0]                  eff_cols_o,
  output logic [wcps_pkg::CfgFramesW-1:0] eff_frames_o,
  output logic [RW-1:0]                  eff_rows_o,
  output logic                           rearm_o
);

  logic [wcps_pkg::CfgColumnsW-1:0] cols_q, cols_d;
  logic [wcps_pkg::CfgFramesW-1:0]  frames_q, frames_d;
  logic [wcps_pkg::CfgRowsW-1:0]    rows_q, rows_d;
  logic [CW-1:0]                    eff_cols_q, eff_cols_d;
  logic [wcps_pkg::CfgFramesW-1:0]  eff_frames_q, eff_frames_d;
  logic [RW-1:0]                    eff_rows_q, eff_rows_d;
  logic [1:0]                       pend_q, pend_d;
  logic                             wr, wr_hit;
  logic [31:0]                      cols_ext, rows_ext;
  logic [wcps_pkg::CfgFramesW-1:0]  cols_frames;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i & cfg_ready_o;

  // A beat to an index past the register list changes nothing.
  always_comb begin
    cols_d   = cols_q;
    frames_d = frames_q;
    rows_d   = rows_q;
    wr_hit   = 1'b0;
    if (wr) begin
      unique case (wcps_pkg::cfg_reg_e'(cfg_index_i))
        wcps_pkg::CFG_COLUMNS: begin
          cols_d = cfg_data_i[wcps_pkg::CfgColumnsW-1:0];
          wr_hit = 1'b1;
        end
        wcps_pkg::CFG_FRAME_COUNT: begin
          frames_d = cfg_data_i[wcps_pkg::CfgFramesW-1:0];
          wr_hit   = 1'b1;
        end
        wcps_pkg::CFG_ROWS: begin
          rows_d = cfg_data_i[wcps_pkg::CfgRowsW-1:0];
          wr_hit = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Clamp zero to one and saturate at the configured maximum.
  always_comb begin
    cols_ext = 32'(cols_q);
    rows_ext = 32'(rows_q);
    if (cols_ext == 32'd0) begin
      eff_cols_d = CW'(1);
    end else if (cols_ext > 32'(MAX_COLUMNS)) begin
      eff_cols_d = CW'(MAX_COLUMNS);
    end else begin
      eff_cols_d = CW'(cols_ext);
    end
    if (rows_ext == 32'd0) begin
      eff_rows_d = RW'(1);
    end else if (rows_ext > 32'(MAX_ROWS)) begin
      eff_rows_d = RW'(MAX_ROWS);
    end else begin
      eff_rows_d = RW'(rows_ext);
    end
    cols_frames  = wcps_pkg::CfgFramesW'(eff_cols_d);
    eff_frames_d = (frames_q < cols_frames) ? cols_frames : frames_q;
  end

  // Re-arm holds while first the register and then its clamped copy update.
  always_comb begin
    if (wr_hit) begin
      pend_d = 2'd2;
    end else if (pend_q != 2'd0) begin
      pend_d = pend_q - 2'd1;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q       <= wcps_pkg::ColumnsRst;
      frames_q     <= wcps_pkg::FramesRst;
      rows_q       <= wcps_pkg::RowsRst;
      eff_cols_q   <= CW'(1);
      eff_frames_q <= wcps_pkg::CfgFramesW'(1);
      eff_rows_q   <= RW'(1);
      pend_q       <= 2'd2;
    end else begin
      cols_q       <= cols_d;
      frames_q     <= frames_d;
      rows_q       <= rows_d;
      eff_cols_q   <= eff_cols_d;
      eff_frames_q <= eff_frames_d;
      eff_rows_q   <= eff_rows_d;
      pend_q       <= pend_d;
    end
  end

  assign eff_cols_o   = eff_cols_q;
  assign eff_frames_o = eff_frames_q;
  assign eff_rows_o   = eff_rows_q;
  assign rearm_o      = (pend_q != 2'd0);

endmodule

@@ rtl/core/wcps_bin.sv @@
// Bin tracker: add-only bin-end accumulators, running min/max and the
// closed-bin record register. Depends on wcps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wcps_bin #(
  parameter int MAX_COLUMNS = wcps_pkg::MaxColumnsDef,
  parameter int SAMPLE_BITS = wcps_pkg::SampleBitsDef,
  localparam int CW  = $clog2(MAX_COLUMNS + 1),
  localparam int CIW = $clog2(MAX_COLUMNS),
  localparam int AW  = wcps_pkg::CfgFramesW + CIW + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [CW-1:0]                   eff_cols_i,
  input  logic [wcps_pkg::CfgFramesW-1:0] eff_frames_i,
  input  logic                            rearm_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   left_i,
  input  logic signed [SAMPLE_BITS-1:0]   right_i,
  output logic                            rec_valid_o,
  input  logic                            rec_ready_i,
  output logic [CIW-1:0]                  rec_column_o,
  output logic                            rec_last_o,
  output logic signed [SAMPLE_BITS-1:0]   rec_min_o,
  output logic signed [SAMPLE_BITS-1:0]   rec_max_o
);

  logic [CIW-1:0]                 col_q, col_d;
  logic [AW-1:0]                  bin_end_q, bin_end_d;
  logic [AW-1:0]                  thr_q, thr_d;
  logic signed [SAMPLE_BITS-1:0]  min_q, min_d, max_q, max_d;
  logic signed [SAMPLE_BITS-1:0]  min_n, max_n;
  logic                           rec_valid_q, rec_valid_d;
  logic [CIW-1:0]                 rec_col_q;
  logic                           rec_last_q;
  logic signed [SAMPLE_BITS-1:0]  rec_min_q, rec_max_q;
  logic                           rec_free, accept, emit, last;
  logic [AW-1:0]                  w_acc, n_acc;

  assign rec_free   = !rec_valid_q || rec_ready_i;
  assign in_ready_o = !rearm_i && rec_free;
  assign accept     = in_valid_i && in_ready_o;

  assign w_acc = AW'(eff_cols_i);
  assign n_acc = AW'(eff_frames_i);
  assign emit  = !(thr_q <= bin_end_q);
  assign last  = (CW'(col_q) + CW'(1)) >= eff_cols_i;

  always_comb begin
    min_n = min_q;
    max_n = max_q;
    if (left_i < min_n) min_n = left_i;
    if (left_i > max_n) max_n = left_i;
    if (right_i < min_n) min_n = right_i;
    if (right_i > max_n) max_n = right_i;
  end

  always_comb begin
    col_d     = col_q;
    bin_end_d = bin_end_q;
    thr_d     = thr_q;
    min_d     = min_q;
    max_d     = max_q;
    if (rearm_i) begin
      col_d     = '0;
      bin_end_d = n_acc;
      thr_d     = w_acc << 1;
      min_d     = '0;
      max_d     = '0;
    end else if (accept) begin
      if (!emit) begin
        thr_d = thr_q + w_acc;
        min_d = min_n;
        max_d = max_n;
      end else if (last) begin
        col_d     = '0;
        bin_end_d = n_acc;
        thr_d     = w_acc << 1;
        min_d     = '0;
        max_d     = '0;
      end else begin
        col_d     = col_q + CIW'(1);
        bin_end_d = bin_end_q + n_acc;
        thr_d     = thr_q + w_acc;
        min_d     = '0;
        max_d     = '0;
      end
    end
  end

  always_comb begin
    rec_valid_d = rec_valid_q;
    if (rec_valid_q && rec_ready_i) rec_valid_d = 1'b0;
    if (accept && emit) rec_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      bin_end_q   <= '0;
      thr_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      bin_end_q   <= bin_end_d;
      thr_q       <= thr_d;
      min_q       <= min_d;
      max_q       <= max_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  // Record payload: load on a closing beat only.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      rec_col_q  <= col_q;
      rec_last_q <= last;
      rec_min_q  <= min_n;
      rec_max_q  <= max_n;
    end
  end

  assign rec_valid_o  = rec_valid_q;
  assign rec_column_o = rec_col_q;
  assign rec_last_o   = rec_last_q;
  assign rec_min_o    = rec_min_q;
  assign rec_max_o    = rec_max_q;

  `WCPS_ASSERT(a_last_wraps, clk_i, rst_ni,
    (accept && emit && last) |=> (col_q == '0))
  `WCPS_ASSERT_MSG(a_col_in_range, clk_i, rst_ni,
    (!rearm_i) |-> (CW'(col_q) < eff_cols_i), "column index past column count")

endmodule

@@ rtl/core/wcps_row.sv @@
// Row mapper: scales bin min/max to pixel rows with one multiply each,
// clamps the bottom row and holds the result beat. Depends on wcps_pkg
// and assert_macros.svh.
`include "assert_macros.svh"

module wcps_row #(
  parameter int MAX_COLUMNS = wcps_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = wcps_pkg::MaxRowsDef,
  parameter int SAMPLE_BITS = wcps_pkg::SampleBitsDef,
  localparam int CIW = $clog2(MAX_COLUMNS),
  localparam int RW  = $clog2(MAX_ROWS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [RW-1:0]                 eff_rows_i,
  input  logic                          rec_valid_i,
  output logic                          rec_ready_o,
  input  logic [CIW-1:0]                rec_column_i,
  input  logic                          rec_last_i,
  input  logic signed [SAMPLE_BITS-1:0] rec_min_i,
  input  logic signed [SAMPLE_BITS-1:0] rec_max_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CIW-1:0]                out_column_o,
  output logic [RW-1:0]                 out_top_o,
  output logic [RW-1:0]                 out_bottom_o,
  output logic                          out_last_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = RW + SB + 1;
  localparam logic [SB+1:0] FullScale = (SB + 2)'(1) << (SB - 1);

  logic [SB+1:0]   top_diff, bot_diff;
  logic [SB:0]     top_span, bot_span;
  logic [PW-1:0]   top_prod, bot_prod;
  logic [RW-1:0]   top_row, bot_row, bot_clamped, h_max;
  logic            out_valid_q, out_valid_d, load;
  logic [CIW-1:0]  col_q;
  logic [RW-1:0]   top_q, bot_q;
  logic            last_q;

  assign rec_ready_o = !out_valid_q || out_ready_i;
  assign load        = rec_valid_i && rec_ready_o;

  // Span is (1 - v) in units of 2^-(SB-1); range 1 .. 2^SB.
  assign top_diff = FullScale - {{2{rec_max_i[SB-1]}}, rec_max_i};
  assign bot_diff = FullScale - {{2{rec_min_i[SB-1]}}, rec_min_i};
  assign top_span = top_diff[SB:0];
  assign bot_span = bot_diff[SB:0];
  assign top_prod = PW'(eff_rows_i) * PW'(top_span);
  assign bot_prod = PW'(eff_rows_i) * PW'(bot_span);
  assign top_row  = top_prod[SB+RW-1:SB];
  assign bot_row  = bot_prod[SB+RW-1:SB];
  assign h_max    = eff_rows_i - RW'(1);

  // A bin minimum of full negative scale lands one past the last row.
  assign bot_clamped = (bot_row > h_max) ? h_max : bot_row;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q  <= rec_column_i;
      top_q  <= top_row;
      bot_q  <= bot_clamped;
      last_q <= rec_last_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_column_o = col_q;
  assign out_top_o    = top_q;
  assign out_bottom_o = bot_q;
  assign out_last_o   = last_q;

  `WCPS_ASSERT_MSG(a_span_ordered, clk_i, rst_ni,
    out_valid_q |-> (top_q <= bot_q), "top row below bottom row")

endmodule

@@ rtl/core/waveform_column_peak_span_top.sv @@
// Top level of the waveform column peak span block: stream ports, config
// write channel, and the cfg / bin / row stages. Depends on wcps_pkg,
// wcps_cfg, wcps_bin and wcps_row.

// Min/max peak decimation of a stereo stream into image column spans.
// One stereo frame is taken per clock unless s_axis_tready is held low by
// re-arm or by an untaken record; the bin tracker updates its
// accumulators and running min/max in the cycle the beat is accepted, so
// there is no gap between frames. A column result passes through the bin
// record register and then the row multiply and output register before it
// appears on the master side. After reset and after every write to one of
// the three registers the block re-arms for a new image, during which
// s_axis_tready is low; a write to an index past the register list is
// dropped. Config writes are always taken. Column, top row and bottom row
// travel in m_axis_tdata, and tlast marks the image's final column.
module waveform_column_peak_span_top #(
  parameter int MAX_COLUMNS = wcps_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = wcps_pkg::MaxRowsDef,
  parameter int SAMPLE_BITS = wcps_pkg::SampleBitsDef,
  localparam int InTdataW   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wcps_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [wcps_pkg::CfgDataW-1:0]    cfg_data_i,
  // Frame stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: left_sample, right_sample (low bits first), zero padded
  input  logic [InTdataW-1:0]              s_axis_tdata,
  // Column result stream out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: column[11:0], top_row[22:12], bottom_row[33:23], zero padded
  output logic [wcps_pkg::OutTdataW-1:0]   m_axis_tdata,
  // tlast: final_column
  output logic                             m_axis_tlast
);

  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int PadW = wcps_pkg::OutTdataW - wcps_pkg::ColumnW - 2 * wcps_pkg::RowW;

  logic [CW-1:0]                   eff_cols;
  logic [wcps_pkg::CfgFramesW-1:0] eff_frames;
  logic [RW-1:0]                   eff_rows;
  logic                            rearm;
  logic                            rec_valid, rec_ready, rec_last;
  logic [CIW-1:0]                  rec_column;
  logic signed [SAMPLE_BITS-1:0]   rec_min, rec_max;
  logic [CIW-1:0]                  out_column;
  logic [RW-1:0]                   out_top, out_bottom;

  wcps_cfg #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .eff_cols_o   (eff_cols),
    .eff_frames_o (eff_frames),
    .eff_rows_o   (eff_rows),
    .rearm_o      (rearm)
  );

  wcps_bin #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_bin (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_cols_i   (eff_cols),
    .eff_frames_i (eff_frames),
    .rearm_i      (rearm),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .left_i       ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .right_i      ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .rec_valid_o  (rec_valid),
    .rec_ready_i  (rec_ready),
    .rec_column_o (rec_column),
    .rec_last_o   (rec_last),
    .rec_min_o    (rec_min),
    .rec_max_o    (rec_max)
  );

  wcps_row #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_row (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_rows_i   (eff_rows),
    .rec_valid_i  (rec_valid),
    .rec_ready_o  (rec_ready),
    .rec_column_i (rec_column),
    .rec_last_i   (rec_last),
    .rec_min_i    (rec_min),
    .rec_max_i    (rec_max),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_column_o (out_column),
    .out_top_o    (out_top),
    .out_bottom_o (out_bottom),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {PadW'(0),
                         wcps_pkg::RowW'(out_bottom),
                         wcps_pkg::RowW'(out_top),
                         wcps_pkg::ColumnW'(out_column)};

endmodule

@@ test/tb.sv @@
// Testbench for waveform_column_peak_span_top: stereo frames in, column spans out,
// each span checked against a cycle-free model of the bin tracker and row mapping.
// Depends on wcps_pkg and the RTL under rtl/core only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleW    = wcps_pkg::SampleBitsDef;
  localparam int InW        = ((2 * SampleW + 7) / 8) * 8;
  localparam int StallPct   = 11;
  localparam int SettleCyc  = 4;
  localparam int DrainCyc   = 10;
  localparam int QuietLimit = 2000;
  localparam int WideFrames = 1024;
  localparam int RandPasses = 6;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [wcps_pkg::CfgIndexW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [wcps_pkg::ColumnW-1:0] column;
    logic [wcps_pkg::RowW-1:0]    top;
    logic [wcps_pkg::RowW-1:0]    bottom;
    logic                         last;
  } col_span_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [wcps_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [wcps_pkg::CfgDataW-1:0]  cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [InW-1:0]                 s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [wcps_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  // Register copies and image state of the span predictor
  int unsigned       reg_columns = wcps_pkg::ColumnsRst;
  int unsigned       reg_frames  = wcps_pkg::FramesRst;
  int unsigned       reg_rows    = wcps_pkg::RowsRst;
  int unsigned       col_idx;
  longint unsigned   bin_end;
  longint unsigned   frame_mark;
  int                peak_min;
  int                peak_max;

  col_span_t span_q[$];

  bit no_stall = 1'b0;
  int mismatches = 0;
  int frames_sent = 0;
  int spans_seen = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  waveform_column_peak_span_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned image_columns();
    if (reg_columns == 0) return 1;
    if (reg_columns > wcps_pkg::MaxColumnsDef) return wcps_pkg::MaxColumnsDef;
    return reg_columns;
  endfunction

  function automatic longint unsigned image_frames();
    longint unsigned w;
    w = image_columns();
    return (reg_frames < w) ? w : reg_frames;
  endfunction

  function automatic longint unsigned image_rows();
    if (reg_rows == 0) return 1;
    if (reg_rows > wcps_pkg::MaxRowsDef) return wcps_pkg::MaxRowsDef;
    return reg_rows;
  endfunction

  function automatic void restart_image();
    col_idx    = 0;
    bin_end    = image_frames();
    frame_mark = 2 * image_columns();
    peak_min   = 0;
    peak_max   = 0;
  endfunction

  // floor(H * (1 - peak) / 2) with peak in Q1.15
  function automatic longint unsigned row_from_peak(int peak, longint unsigned h);
    longint unsigned span;
    span = longint'(1 << (SampleW - 1)) - peak;
    return (h * span) >> SampleW;
  endfunction

  function automatic void apply_register(logic [wcps_pkg::CfgIndexW-1:0] idx,
                                         logic [wcps_pkg::CfgDataW-1:0] value);
    case (idx)
      wcps_pkg::CFG_COLUMNS:     reg_columns = value[wcps_pkg::CfgColumnsW-1:0];
      wcps_pkg::CFG_FRAME_COUNT: reg_frames  = value[wcps_pkg::CfgFramesW-1:0];
      wcps_pkg::CFG_ROWS:        reg_rows    = value[wcps_pkg::CfgRowsW-1:0];
      default:                   return;
    endcase
    restart_image();
  endfunction

  function automatic void track_frame(shortint left, shortint right);
    col_span_t       s;
    longint unsigned h;
    longint unsigned low_row;
    if (left < peak_min) peak_min = left;
    if (left > peak_max) peak_max = left;
    if (right < peak_min) peak_min = right;
    if (right > peak_max) peak_max = right;
    if (frame_mark <= bin_end) begin
      frame_mark += image_columns();
      return;
    end
    h = image_rows();
    low_row = row_from_peak(peak_min, h);
    if (low_row > h - 1) low_row = h - 1;
    s.column = col_idx[wcps_pkg::ColumnW-1:0];
    s.top    = wcps_pkg::RowW'(row_from_peak(peak_max, h));
    s.bottom = wcps_pkg::RowW'(low_row);
    s.last   = (col_idx + 1 >= image_columns());
    span_q.push_back(s);
    if (s.last) begin
      restart_image();
    end else begin
      col_idx++;
      bin_end    += image_frames();
      frame_mark += image_columns();
      peak_min = 0;
      peak_max = 0;
    end
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void field_check(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    col_span_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      spans_seen++;
      if (span_q.size() == 0) begin
        $display("%0t: unexpected span for column %0d", $time, m_axis_tdata[11:0]);
        mismatches++;
      end else begin
        want = span_q.pop_front();
        field_check("column", want.column, m_axis_tdata[11:0]);
        field_check("top_row", want.top, m_axis_tdata[22:12]);
        field_check("bottom_row", want.bottom, m_axis_tdata[33:23]);
        field_check("final_column", want.last, m_axis_tlast);
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= no_stall || ($urandom_range(99) >= StallPct);
  end

  // Stop the run when no channel moves a beat for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, QuietLimit);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_frame(input shortint left, input shortint right);
    int gap;
    gap = (!no_stall && $urandom_range(99) < StallPct) ? 1 : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InW'({right, left});
    do @(posedge clk_i); while (!s_axis_tready);
    track_frame(left, right);
    frames_sent++;
  endtask

  // Drop the stream and let every pending span drain out
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [wcps_pkg::CfgIndexW-1:0] idx,
                                input logic [wcps_pkg::CfgDataW-1:0] value);
    settle_block();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, value);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_image(input logic [wcps_pkg::CfgDataW-1:0] cols,
                           input logic [wcps_pkg::CfgDataW-1:0] frames,
                           input logic [wcps_pkg::CfgDataW-1:0] nrows);
    write_register(wcps_pkg::CFG_COLUMNS, cols);
    write_register(wcps_pkg::CFG_FRAME_COUNT, frames);
    write_register(wcps_pkg::CFG_ROWS, nrows);
  endtask

  // Weight the extremes and small amplitudes
  function automatic shortint pick_sample();
    case ($urandom_range(9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2, 3:    return shortint'($urandom_range(511)) - 16'sd256;
      default: return shortint'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    // Default image needs 1024 frames per column: nothing may close yet
    send_frame(16'sd32767, -16'sd32768);
    send_frame(16'sd0, 16'sd0);
    send_frame(-16'sd1, 16'sd1);
  endtask

  task automatic test_sample_extremes();
    set_image(4, 4, 512);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(16'sd0, 16'sd0);
    send_frame(-16'sd32768, -16'sd32768);
    send_frame(16'sd32767, 16'sd32767);
    send_frame(16'sd1, -16'sd1);
    send_frame(-16'sd1, 16'sd1);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd16384, -16'sd16384);
  endtask

  task automatic test_register_extremes();
    // Zero columns and rows fall back to one; high bits are masked off
    set_image(32'hFFFF_E000, 0, 32'hFFFF_F000);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd5, -16'sd5);
    // Largest frame count: the single bin stays open
    set_image(1, 32'hFFFF_FFFF, 2048);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd100, -16'sd100);
    // Frame count below columns is raised: one frame per bin
    set_image(3, 1, 1);
    send_frame(-16'sd32768, 16'sd0);
    send_frame(16'sd32767, 16'sd0);
    send_frame(16'sd0, -16'sd2);
  endtask

  task automatic test_unused_index();
    set_image(2, 6, 100);
    send_frame(16'sd1000, -16'sd2000);
    send_frame(-16'sd32768, 16'sd32767);
    // Must not restart the image half way through the first bin
    write_register(CfgUnused, 32'hFFFF_FFFF);
    repeat (4) send_frame(pick_sample(), pick_sample());
  endtask

  task automatic test_wide_image();
    int i;
    // Saturated width and height, one frame per column over the first
    // columns of the image, no idling anywhere
    no_stall = 1'b1;
    set_image(32'h0000_1FFF, 16777216 - 16777216, 32'h0000_0FFF);
    for (i = 0; i < WideFrames; i++) send_frame(pick_sample(), pick_sample());
    settle_block();
    no_stall = 1'b0;
  endtask

  task automatic test_random_images();
    int pass;
    int i;
    int unsigned cols;
    int unsigned frames;
    int unsigned nrows;
    for (pass = 0; pass < RandPasses; pass++) begin
      case ($urandom_range(7))
        0:       cols = $urandom_range(8191);
        1:       cols = $urandom_range(17, 64);
        default: cols = $urandom_range(0, 16);
      endcase
      frames = ($urandom_range(3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 80);
      case ($urandom_range(5))
        0:       nrows = $urandom_range(0, 2);
        1:       nrows = 2048;
        2:       nrows = $urandom_range(2049, 4095);
        default: nrows = $urandom_range(1, 2047);
      endcase
      // Random upper bits exercise register masking
      set_image({$urandom_range(1) ? 19'h7FFFF : 19'h0, cols[12:0]}, frames,
                {$urandom_range(1) ? 20'hFFFFF : 20'h0, nrows[11:0]});
      for (i = 0; i < 170; i++) send_frame(pick_sample(), pick_sample());
    end
  endtask

  initial begin
    restart_image();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_sample_extremes();
    test_register_extremes();
    test_unused_index();
    test_wide_image();
    test_random_images();

    settle_block();
    repeat (DrainCyc) @(posedge clk_i);
    mismatches += span_q.size();

    $display("Sent %0d stereo frames over %0d register writes; checked %0d column spans.",
             frames_sent, reg_writes, spans_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ waveform_column_peak_span_top.f @@
+incdir+rtl/core
rtl/core/wcps_pkg.sv
rtl/core/wcps_cfg.sv
rtl/core/wcps_bin.sv
rtl/core/wcps_row.sv
rtl/core/waveform_column_peak_span_top.sv
test/tb.sv
